// ----- design/qif_neuron_update_top_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the neuron update block.
// Concurrent assertions written in one house form.
// ---------------------------------------------------------------------------
`ifndef QIF_NEURON_UPDATE_TOP_MACROS_SVH
`define QIF_NEURON_UPDATE_TOP_MACROS_SVH

// Implication in the same cycle, disabled while reset is asserted.
`define QNU_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication into the next cycle, also checked across reset.
`define QNU_ASSERT_NEXT(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ----- design/qnu_pkg.sv -----
// ---------------------------------------------------------------------------
// qnu_pkg
// Widths, reset values, register codes and helpers shared by the neuron
// update block.
// ---------------------------------------------------------------------------
`default_nettype none

package qnu_pkg;

    localparam int NEURONS_DEF = 1024;

    localparam int IDX_W      = 10;
    localparam int TIME_W     = 32;
    localparam int POT_W      = 32;
    localparam int CNT_W      = 16;
    localparam int GAIN_W     = 31;
    localparam int STEP_W     = 25;
    localparam int PEAK_W     = 31;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GAIN = 2'd0,
        REG_STEP = 2'd1,
        REG_PEAK = 2'd2
    } t_reg_idx;

    localparam logic [GAIN_W-1:0] GAIN_RST = 31'd983040000;
    localparam logic [STEP_W-1:0] STEP_RST = 25'd1678;
    localparam logic [PEAK_W-1:0] PEAK_RST = 31'd6553600;

    localparam logic [POT_W-1:0]  MEM_V_RST   = 32'hFF9C_0000;
    localparam logic [TIME_W-1:0] MEM_REL_RST = 32'h8000_0000;

    // Synaptic divider: gain * active over fan-in.
    localparam int SYN_NUM_W = GAIN_W + CNT_W;
    localparam int SYN_DEN_W = CNT_W;

    // Reciprocal divider: 2^40 over a non-negative potential.
    localparam int REC_NUM_W = 41;
    localparam int REC_DEN_W = 31;
    localparam logic [REC_NUM_W-1:0] REC_ONE = 41'h100_0000_0000;

    // Hazard window depth: a new item on a neuron still inside it collides on state.
    localparam int HZ_DEPTH = REC_NUM_W + 10;

    typedef struct packed {
        logic [IDX_W-1:0]         idx;
        logic signed [TIME_W-1:0] now;
        logic signed [32:0]       bd;
        logic                     fan_zero;
        logic                     in_range;
    } t_syn_tag;

    typedef struct packed {
        logic [IDX_W-1:0]         idx;
        logic signed [TIME_W-1:0] now;
        logic signed [TIME_W-1:0] rel;
        logic signed [POT_W-1:0]  vn;
        logic                     fire;
        logic                     upd;
        logic                     in_range;
        logic                     vzero;
    } t_rec_tag;

    function automatic logic signed [31:0] f_sat32(input logic signed [63:0] x);
        logic signed [31:0] r;
        if (x > 64'sd2147483647) begin
            r = 32'sh7FFF_FFFF;
        end else if (x < -64'sd2147483648) begin
            r = 32'sh8000_0000;
        end else begin
            r = x[31:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- design/qif_neuron_update_top.sv -----
// ---------------------------------------------------------------------------
// qif_neuron_update_top
// Quadratic integrate-and-fire neuron update, one Euler step per item, with
// per-neuron potential and release time held in on-chip RAM.
// ---------------------------------------------------------------------------
//
//   Channel   Direction  Handshake                  Payload
//   --------  ---------  -------------------------  ------------------------
//   command   in         start, busy                neuron, now, bias,
//                                                   active_inputs, fan_in,
//                                                   drive
//   result    out        o_valid (one-cycle strobe) neuron_out, potential,
//                                                   fired, spike_time, settled
//   config    in         i_cfg_valid, o_cfg_ready   i_cfg_index, i_cfg_data
//
// An item is accepted on a rising edge with start high and busy low, and its
// result strobes out after stage A, the synaptic divider, stages B to H, the
// reciprocal divider and the stage J output registers.
// One item is accepted per cycle while busy is low. busy rises only when the
// incoming neuron index matches an item still in the HZ_DEPTH-entry hazard
// window, since the state RAM is read after the synaptic divider and written
// back at the end of the pipe. After reset a clearing pass writes every RAM
// entry with busy held high; configuration writes are taken at all times.
// The result side cannot stall, so the pipeline never stops once started.
// ---------------------------------------------------------------------------
`default_nettype none

module qif_neuron_update_top
    import qnu_pkg::*;
#(
    parameter int NEURONS = NEURONS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic [IDX_W-1:0]      i_neuron,
    input  wire logic [TIME_W-1:0]     i_now,
    input  wire logic [POT_W-1:0]      i_bias,
    input  wire logic [CNT_W-1:0]      i_active_inputs,
    input  wire logic [CNT_W-1:0]      i_fan_in,
    input  wire logic [POT_W-1:0]      i_drive,
    output logic                       o_valid,
    output logic      [IDX_W-1:0]      o_neuron_out,
    output logic      [POT_W-1:0]      o_potential,
    output logic                       o_fired,
    output logic      [TIME_W-1:0]     o_spike_time,
    output logic                       o_settled,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int ADDR_W = (NEURONS > 1) ? $clog2(NEURONS) : 1;
    localparam int MEM_W  = POT_W + TIME_W;

    // Context that rides along the middle stages.
    typedef struct packed {
        logic [IDX_W-1:0]         idx;
        logic signed [TIME_W-1:0] now;
        logic                     inr;
        logic signed [POT_W-1:0]  v;
        logic signed [TIME_W-1:0] rel;
        logic                     upd;
        logic signed [POT_W-1:0]  cur;
    } t_core;

    // ---------------- configuration registers ----------------
    logic [GAIN_W-1:0] r_gain;
    logic [STEP_W-1:0] r_step;
    logic [PEAK_W-1:0] r_peak;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= GAIN_RST;
            r_step <= STEP_RST;
            r_peak <= PEAK_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_GAIN: r_gain <= i_cfg_data[GAIN_W-1:0];
                REG_STEP: r_step <= i_cfg_data[STEP_W-1:0];
                REG_PEAK: r_peak <= i_cfg_data[PEAK_W-1:0];
                default:  ;
            endcase
        end
    end

    // ---------------- clearing pass and hazard window ----------------
    logic              r_clr;
    logic [ADDR_W-1:0] r_clr_addr;
    logic              r_hz_v   [HZ_DEPTH];
    logic [IDX_W-1:0]  r_hz_idx [HZ_DEPTH];
    logic              w_hazard;
    logic              w_accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr      <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr) begin
            if (r_clr_addr == ADDR_W'(NEURONS - 1)) begin
                r_clr <= 1'b0;
            end
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    // A new item must not read state that an item still in flight will write.
    always_comb begin
        w_hazard = 1'b0;
        for (int k = 0; k < HZ_DEPTH; k++) begin
            if (r_hz_v[k] && (r_hz_idx[k] == i_neuron)) begin
                w_hazard = 1'b1;
            end
        end
    end

    assign busy     = r_clr || w_hazard;
    assign w_accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < HZ_DEPTH; k++) begin
                r_hz_v[k] <= 1'b0;
            end
        end else begin
            r_hz_v[0] <= w_accept;
            for (int k = 1; k < HZ_DEPTH; k++) begin
                r_hz_v[k] <= r_hz_v[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_hz_idx[0] <= i_neuron;
        for (int k = 1; k < HZ_DEPTH; k++) begin
            r_hz_idx[k] <= r_hz_idx[k-1];
        end
    end

    // ---------------- stage A: synaptic product, bias plus drive ----------------
    logic                 r_a_v;
    t_syn_tag             r_a_tag;
    logic [SYN_NUM_W-1:0] r_a_prod;
    logic [SYN_DEN_W-1:0] r_a_fan;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
        end else begin
            r_a_v <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_tag.idx      <= i_neuron;
        r_a_tag.now      <= $signed(i_now);
        r_a_tag.bd       <= $signed({i_bias[POT_W-1], i_bias})
                          + $signed({i_drive[POT_W-1], i_drive});
        r_a_tag.fan_zero <= (i_fan_in == '0);
        r_a_tag.in_range <= ({22'd0, i_neuron} < 32'(NEURONS));
        r_a_prod         <= {{CNT_W{1'b0}}, r_gain} * {{GAIN_W{1'b0}}, i_active_inputs};
        r_a_fan          <= i_fan_in;
    end

    // ---------------- synaptic divider ----------------
    logic                 w_d1_v;
    logic [SYN_NUM_W-1:0] w_d1_q;
    t_syn_tag             w_d1_tag;

    qnu_div_pipe #(
        .NUM_W (SYN_NUM_W),
        .DEN_W (SYN_DEN_W),
        .TAG_W ($bits(t_syn_tag))
    ) u_syn_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_a_v),
        .i_num   (r_a_prod),
        .i_den   (r_a_fan),
        .i_tag   (r_a_tag),
        .o_valid (w_d1_v),
        .o_quo   (w_d1_q),
        .o_tag   (w_d1_tag)
    );

    // ---------------- state RAM ----------------
    logic              r_wb_en;
    logic [ADDR_W-1:0] r_wb_addr;
    logic [MEM_W-1:0]  r_wb_data;
    logic              w_we;
    logic [ADDR_W-1:0] w_waddr;
    logic [MEM_W-1:0]  w_wdata;
    logic [MEM_W-1:0]  w_rdata;

    assign w_we    = r_clr || r_wb_en;
    assign w_waddr = r_clr ? r_clr_addr : r_wb_addr;
    assign w_wdata = r_clr ? {MEM_V_RST, MEM_REL_RST} : r_wb_data;

    qnu_ram #(
        .WIDTH (MEM_W),
        .DEPTH (NEURONS)
    ) u_state_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (ADDR_W'(w_d1_tag.idx)),
        .o_rdata (w_rdata)
    );

    // ---------------- stage B: input current ----------------
    logic               r_b_v;
    t_core              r_b_core;
    logic [31:0]        n_b_syn;

    always_comb begin
        if (w_d1_tag.fan_zero) begin
            n_b_syn = '0;
        end else if (|w_d1_q[SYN_NUM_W-1:31]) begin
            n_b_syn = 32'h7FFF_FFFF;
        end else begin
            n_b_syn = {1'b0, w_d1_q[30:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_v <= 1'b0;
        end else begin
            r_b_v <= w_d1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b_core.idx <= w_d1_tag.idx;
        r_b_core.now <= w_d1_tag.now;
        r_b_core.inr <= w_d1_tag.in_range;
        r_b_core.v   <= '0;
        r_b_core.rel <= '0;
        r_b_core.upd <= 1'b0;
        r_b_core.cur <= f_sat32($signed({{31{w_d1_tag.bd[32]}}, w_d1_tag.bd})
                              + $signed({32'd0, n_b_syn}));
    end

    // ---------------- stage C: state read, refractory test, magnitude ----------------
    logic               r_c_v;
    t_core              r_c_core;
    logic [31:0]        r_c_mag;
    logic signed [31:0] n_c_v;
    logic signed [31:0] n_c_rel;

    assign n_c_v   = $signed(w_rdata[MEM_W-1:TIME_W]);
    assign n_c_rel = $signed(w_rdata[TIME_W-1:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_v <= 1'b0;
        end else begin
            r_c_v <= r_b_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_c_core.idx <= r_b_core.idx;
        r_c_core.now <= r_b_core.now;
        r_c_core.inr <= r_b_core.inr;
        r_c_core.cur <= r_b_core.cur;
        r_c_core.v   <= n_c_v;
        r_c_core.rel <= n_c_rel;
        r_c_core.upd <= r_b_core.inr && (r_b_core.now > n_c_rel);
        r_c_mag      <= n_c_v[31] ? 32'(-n_c_v) : n_c_v;
    end

    // ---------------- stage D: square ----------------
    logic        r_d_v;
    t_core       r_d_core;
    logic [47:0] r_d_sq;
    logic [63:0] n_d_sq;

    assign n_d_sq = {32'd0, r_c_mag} * {32'd0, r_c_mag};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_v <= 1'b0;
        end else begin
            r_d_v <= r_c_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_d_core <= r_c_core;
        r_d_sq   <= n_d_sq[63:16];
    end

    // ---------------- stage E: derivative and its magnitude ----------------
    logic               r_e_v;
    t_core              r_e_core;
    logic [48:0]        r_e_mag;
    logic               r_e_neg;
    logic signed [49:0] n_e_dv;
    logic signed [49:0] n_e_ndv;

    assign n_e_dv  = $signed({2'b00, r_d_sq})
                   + $signed({{18{r_d_core.cur[31]}}, r_d_core.cur});
    assign n_e_ndv = -n_e_dv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_v <= 1'b0;
        end else begin
            r_e_v <= r_d_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_e_core <= r_d_core;
        r_e_neg  <= n_e_dv[49];
        r_e_mag  <= n_e_dv[49] ? n_e_ndv[48:0] : n_e_dv[48:0];
    end

    // ---------------- stage F: step products ----------------
    logic        r_f_v;
    t_core       r_f_core;
    logic        r_f_neg;
    logic [49:0] r_f_hi;
    logic [24:0] r_f_lo;
    logic [48:0] n_f_lo;

    assign n_f_lo = {25'd0, r_e_mag[23:0]} * {24'd0, r_step};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_v <= 1'b0;
        end else begin
            r_f_v <= r_e_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_f_core <= r_e_core;
        r_f_neg  <= r_e_neg;
        r_f_hi   <= {25'd0, r_e_mag[48:24]} * {25'd0, r_step};
        r_f_lo   <= n_f_lo[48:24];
    end

    // ---------------- stage G: new potential ----------------
    logic               r_g_v;
    t_core              r_g_core;
    logic signed [31:0] r_g_vn;
    logic [50:0]        n_g_inc;
    logic signed [63:0] n_g_res;

    always_comb begin
        n_g_inc = {1'b0, r_f_hi} + {26'd0, r_f_lo};
        if (r_f_neg) begin
            n_g_res = $signed({{32{r_f_core.v[31]}}, r_f_core.v}) - $signed({13'd0, n_g_inc});
        end else begin
            n_g_res = $signed({{32{r_f_core.v[31]}}, r_f_core.v}) + $signed({13'd0, n_g_inc});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g_v <= 1'b0;
        end else begin
            r_g_v <= r_f_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_g_core <= r_f_core;
        r_g_vn   <= r_f_core.upd ? f_sat32(n_g_res) : r_f_core.v;
    end

    // ---------------- stage H: peak test ----------------
    logic     r_h_v;
    t_rec_tag r_h_tag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h_v <= 1'b0;
        end else begin
            r_h_v <= r_g_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_h_tag.idx      <= r_g_core.idx;
        r_h_tag.now      <= r_g_core.now;
        r_h_tag.rel      <= r_g_core.rel;
        r_h_tag.vn       <= r_g_vn;
        r_h_tag.fire     <= r_g_core.upd
                         && ($signed({r_g_vn[31], r_g_vn}) >= $signed({2'b00, r_peak}));
        r_h_tag.upd      <= r_g_core.upd;
        r_h_tag.in_range <= r_g_core.inr;
        r_h_tag.vzero    <= (r_g_vn == '0);
    end

    // ---------------- reciprocal divider ----------------
    logic                 w_d2_v;
    logic [REC_NUM_W-1:0] w_d2_q;
    t_rec_tag             w_d2_tag;

    qnu_div_pipe #(
        .NUM_W (REC_NUM_W),
        .DEN_W (REC_DEN_W),
        .TAG_W ($bits(t_rec_tag))
    ) u_rec_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_h_v),
        .i_num   (REC_ONE),
        .i_den   (r_h_tag.vn[REC_DEN_W-1:0]),
        .i_tag   (r_h_tag),
        .o_valid (w_d2_v),
        .o_quo   (w_d2_q),
        .o_tag   (w_d2_tag)
    );

    // ---------------- stage J: spike and release times, result ----------------
    logic [REC_NUM_W-1:0] n_j_rec;
    logic signed [31:0]   n_j_spike;
    logic signed [31:0]   n_j_rel;
    logic signed [31:0]   n_j_pot;
    logic signed [31:0]   n_j_relf;
    logic signed [63:0]   n_j_now64;

    always_comb begin
        n_j_rec   = w_d2_tag.vzero ? REC_ONE : w_d2_q;
        n_j_now64 = $signed({{32{w_d2_tag.now[31]}}, w_d2_tag.now});
        n_j_spike = f_sat32(n_j_now64 + $signed({23'd0, n_j_rec}));
        n_j_rel   = f_sat32(n_j_now64 + $signed({22'd0, n_j_rec, 1'b0}));
        n_j_relf  = w_d2_tag.fire ? n_j_rel : w_d2_tag.rel;
        if (!w_d2_tag.in_range) begin
            n_j_pot = '0;
        end else if (w_d2_tag.fire) begin
            n_j_pot = -w_d2_tag.vn;
        end else begin
            n_j_pot = w_d2_tag.vn;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
            r_wb_en <= 1'b0;
        end else begin
            o_valid <= w_d2_v;
            r_wb_en <= w_d2_v && w_d2_tag.upd;
        end
    end

    always_ff @(posedge i_clk) begin
        o_neuron_out <= w_d2_tag.idx;
        o_potential  <= n_j_pot;
        o_fired      <= w_d2_tag.fire;
        o_spike_time <= w_d2_tag.fire ? n_j_spike : '0;
        o_settled    <= w_d2_tag.in_range && (w_d2_tag.now > n_j_relf);
        r_wb_addr    <= ADDR_W'(w_d2_tag.idx);
        r_wb_data    <= {n_j_pot, n_j_relf};
    end

endmodule

`default_nettype wire

// ----- design/qnu_ram.sv -----
// ---------------------------------------------------------------------------
// qnu_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module qnu_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                     i_wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                     o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ----- design/qnu_div_pipe.sv -----
// ---------------------------------------------------------------------------
// qnu_div_pipe
// Pipelined unsigned restoring divider, one quotient bit per stage.
// ---------------------------------------------------------------------------
`default_nettype none

module qnu_div_pipe
    import qnu_pkg::*;
#(
    parameter int NUM_W = 47,
    parameter int DEN_W = 16,
    parameter int TAG_W = 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    input  wire logic [NUM_W-1:0] i_num,
    input  wire logic [DEN_W-1:0] i_den,
    input  wire logic [TAG_W-1:0] i_tag,
    output logic                  o_valid,
    output logic      [NUM_W-1:0] o_quo,
    output logic      [TAG_W-1:0] o_tag
);

    logic             r_v   [NUM_W];
    logic [DEN_W-1:0] r_rem [NUM_W];
    logic [NUM_W-1:0] r_num [NUM_W];
    logic [NUM_W-1:0] r_quo [NUM_W];
    logic [DEN_W-1:0] r_den [NUM_W];
    logic [TAG_W-1:0] r_tag [NUM_W];

    for (genvar s = 0; s < NUM_W; s++) begin : g_stage
        logic             w_v;
        logic [DEN_W-1:0] w_rem;
        logic [NUM_W-1:0] w_num;
        logic [NUM_W-1:0] w_quo;
        logic [DEN_W-1:0] w_den;
        logic [TAG_W-1:0] w_tag;
        logic [DEN_W:0]   w_trial;
        logic [DEN_W:0]   w_diff;
        logic             w_ge;
        logic [DEN_W-1:0] n_rem;
        logic [NUM_W-1:0] n_quo;

        if (s == 0) begin : g_first
            assign w_v   = i_valid;
            assign w_rem = '0;
            assign w_num = i_num;
            assign w_quo = '0;
            assign w_den = i_den;
            assign w_tag = i_tag;
        end else begin : g_next
            assign w_v   = r_v[s-1];
            assign w_rem = r_rem[s-1];
            assign w_num = r_num[s-1];
            assign w_quo = r_quo[s-1];
            assign w_den = r_den[s-1];
            assign w_tag = r_tag[s-1];
        end

        always_comb begin
            w_trial = {w_rem, w_num[NUM_W-1]};
            w_diff  = w_trial - {1'b0, w_den};
            w_ge    = (w_trial >= {1'b0, w_den});
            n_rem   = w_ge ? w_diff[DEN_W-1:0] : w_trial[DEN_W-1:0];
            n_quo   = {w_quo[NUM_W-2:0], w_ge};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s] <= 1'b0;
            end else begin
                r_v[s] <= w_v;
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[s] <= n_rem;
            r_num[s] <= {w_num[NUM_W-2:0], 1'b0};
            r_quo[s] <= n_quo;
            r_den[s] <= w_den;
            r_tag[s] <= w_tag;
        end
    end

    assign o_valid = r_v[NUM_W-1];
    assign o_quo   = r_quo[NUM_W-1];
    assign o_tag   = r_tag[NUM_W-1];

endmodule

`default_nettype wire

// ----- design/qnu_checker.sv -----
// ---------------------------------------------------------------------------
// qnu_checker
// Port-level checks on the neuron update results, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "qif_neuron_update_top_macros.svh"

module qnu_checker
    import qnu_pkg::*;
#(
    parameter int NEURONS = NEURONS_DEF
) (
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  busy,
    input wire logic                  o_valid,
    input wire logic [IDX_W-1:0]      o_neuron_out,
    input wire logic [POT_W-1:0]      o_potential,
    input wire logic                  o_fired,
    input wire logic [TIME_W-1:0]     o_spike_time,
    input wire logic                  o_settled
);

    // A neuron that just fired has its release time ahead of now.
    `QNU_ASSERT_SAME(a_fire_not_settled, i_clk, i_rst_n, o_valid && o_fired, !o_settled, "fired neuron reported settled")

    // Firing flips a non-negative potential.
    `QNU_ASSERT_SAME(a_fire_pot_sign, i_clk, i_rst_n, o_valid && o_fired, o_potential[POT_W-1] || (o_potential == '0), "fired neuron with positive potential")

    // Without a spike the spike time reads zero.
    `QNU_ASSERT_SAME(a_no_fire_time, i_clk, i_rst_n, o_valid && !o_fired, o_spike_time == '0, "spike time set without a spike")

    // An index outside the array gives an all-zero result.
    `QNU_ASSERT_SAME(a_out_of_range, i_clk, i_rst_n, o_valid && ({22'd0, o_neuron_out} >= 32'(NEURONS)), (o_potential == '0) && !o_fired && !o_settled, "out-of-range index changed the result")

    // The clearing pass holds off commands right after reset.
    `QNU_ASSERT_NEXT(a_busy_after_reset, i_clk, !i_rst_n, busy, "block not busy after reset")

endmodule

bind qif_neuron_update_top qnu_checker #(.NEURONS(NEURONS)) u_qnu_checker (.*);

`default_nettype wire

// ----- test/tb.sv -----
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the neuron update block: a queue-fed driver issues
// items with random gaps, a monitor checks each result strobe against a
// behavioral predictor that tracks potential and release time per neuron.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tb;
    import qnu_pkg::*;

    // Pipeline latency in cycles, plus margin for draining at phase ends.
    localparam int LATENCY = SYN_NUM_W + REC_NUM_W + 8;
    localparam int DRAIN   = LATENCY + 20;

    typedef struct {
        logic [IDX_W-1:0]  neuron;
        logic [TIME_W-1:0] now;
        logic [POT_W-1:0]  bias;
        logic [CNT_W-1:0]  active;
        logic [CNT_W-1:0]  fan;
        logic [POT_W-1:0]  drive;
        int                gap;
    } t_cmd;

    typedef struct {
        logic [IDX_W-1:0]  neuron;
        logic [POT_W-1:0]  potential;
        logic              fired;
        logic [TIME_W-1:0] spike_time;
        logic              settled;
    } t_upd;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic [IDX_W-1:0]      i_neuron = '0;
    logic [TIME_W-1:0]     i_now = '0;
    logic [POT_W-1:0]      i_bias = '0;
    logic [CNT_W-1:0]      i_active_inputs = '0;
    logic [CNT_W-1:0]      i_fan_in = '0;
    logic [POT_W-1:0]      i_drive = '0;
    logic                  o_valid;
    logic [IDX_W-1:0]      o_neuron_out;
    logic [POT_W-1:0]      o_potential;
    logic                  o_fired;
    logic [TIME_W-1:0]     o_spike_time;
    logic                  o_settled;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    qif_neuron_update_top dut (.*);

    always #5 i_clk = ~i_clk;

    // Predictor state: the block's configuration and per-neuron memory.
    logic [GAIN_W-1:0]        gain_q;
    logic [STEP_W-1:0]        step_q;
    logic [PEAK_W-1:0]        peak_q;
    logic signed [POT_W-1:0]  pot_mem [NEURONS_DEF];
    logic signed [TIME_W-1:0] rel_mem [NEURONS_DEF];

    t_cmd pending_cmds[$];
    t_upd expected_upds[$];
    int   mismatches = 0;
    int   spikes_seen = 0;
    int   refractory_seen = 0;
    int   results_seen = 0;
    bit   stim_done = 1'b0;

    function automatic logic signed [63:0] clamp32(input logic signed [63:0] x);
        if (x > 64'sd2147483647) return 64'sd2147483647;
        if (x < -64'sd2147483648) return -64'sd2147483648;
        return x;
    endfunction

    // Computes the result of one accepted item and updates the neuron memory.
    function automatic t_upd euler_update(input t_cmd c);
        t_upd r;
        logic signed [63:0] v, rel, tnow, syn, cur, dv, inc;
        logic [63:0] q, mag, sq, rec;
        r.neuron = c.neuron;
        r.potential = '0;
        r.fired = 1'b0;
        r.spike_time = '0;
        r.settled = 1'b0;
        if (c.neuron >= NEURONS_DEF) return r;
        v = pot_mem[c.neuron];
        rel = rel_mem[c.neuron];
        tnow = $signed(c.now);
        if (tnow > rel) begin
            syn = 0;
            if (c.fan != 0) begin
                q = (64'(gain_q) * 64'(c.active)) / 64'(c.fan);
                syn = (q > 64'd2147483647) ? 64'sd2147483647 : $signed(q);
            end
            cur = clamp32(64'($signed(c.bias)) + 64'($signed(c.drive)) + syn);
            mag = (v < 0) ? -v : v;
            sq = (mag * mag) >> 16;
            dv = $signed(sq) + cur;
            mag = (dv < 0) ? -dv : dv;
            inc = $signed((mag >> 24) * 64'(step_q)
                          + (((mag & 64'hFF_FFFF) * 64'(step_q)) >> 24));
            v = clamp32((dv < 0) ? v - inc : v + inc);
            if (v >= $signed(64'(peak_q))) begin
                rec = (v == 0) ? (64'd1 << 40) : ((64'd1 << 40) / v);
                r.spike_time = 32'(clamp32(tnow + $signed(rec)));
                rel = clamp32(tnow + 2 * $signed(rec));
                v = -v;
                r.fired = 1'b1;
            end
            pot_mem[c.neuron] = 32'(v);
            rel_mem[c.neuron] = 32'(rel);
        end
        r.potential = v[31:0];
        r.settled = tnow > rel;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    // Driver: presents one item at a time after its gap; prediction is done at
    // the accepting edge so the expectation order matches acceptance order.
    int   gap_left = 0;
    bit   have_cmd = 1'b0;
    t_cmd cur_cmd;

    always @(posedge i_clk) begin
        if (start && !busy && i_rst_n) begin
            expected_upds.insert(expected_upds.size(), euler_update(cur_cmd));
            have_cmd = 1'b0;
        end
    end

    always @(negedge i_clk) begin
        if (!have_cmd && pending_cmds.size() > 0) begin
            cur_cmd = pending_cmds.pop_front();
            have_cmd = 1'b1;
            gap_left = cur_cmd.gap;
        end
        if (have_cmd && gap_left > 0) begin
            gap_left--;
            start <= 1'b0;
        end else if (have_cmd) begin
            start <= 1'b1;
            i_neuron <= cur_cmd.neuron;
            i_now <= cur_cmd.now;
            i_bias <= cur_cmd.bias;
            i_active_inputs <= cur_cmd.active;
            i_fan_in <= cur_cmd.fan;
            i_drive <= cur_cmd.drive;
        end else begin
            start <= 1'b0;
        end
    end

    // Monitor: every strobe must match the oldest expectation.
    always @(posedge i_clk) begin
        t_upd e;
        if (i_rst_n && o_valid) begin
            results_seen++;
            if (expected_upds.size() == 0) begin
                report_mismatch("unexpected result", 64'(o_neuron_out), 0);
            end else begin
                e = expected_upds.pop_front();
                if (o_neuron_out !== e.neuron)
                    report_mismatch("neuron_out", 64'(o_neuron_out), 64'(e.neuron));
                if (o_potential !== e.potential)
                    report_mismatch("potential", 64'(o_potential), 64'(e.potential));
                if (o_fired !== e.fired)
                    report_mismatch("fired", 64'(o_fired), 64'(e.fired));
                if (o_spike_time !== e.spike_time)
                    report_mismatch("spike_time", 64'(o_spike_time), 64'(e.spike_time));
                if (o_settled !== e.settled)
                    report_mismatch("settled", 64'(o_settled), 64'(e.settled));
                if (e.fired) spikes_seen++;
                if (!e.settled) refractory_seen++;
            end
        end
    end

    // Writes one register through the configuration channel, and in the
    // predictor at the same time.
    task automatic write_reg(input t_reg_idx idx, input logic [31:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            REG_GAIN: gain_q = data[GAIN_W-1:0];
            REG_STEP: step_q = data[STEP_W-1:0];
            REG_PEAK: peak_q = data[PEAK_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Waits for every item to be taken and every result to come back, then
    // lets the pipeline run dry.
    task automatic wait_idle();
        while (pending_cmds.size() > 0 || have_cmd || expected_upds.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    task automatic queue_cmd(input t_cmd c);
        pending_cmds.insert(pending_cmds.size(), c);
    endtask

    // A random item. Neuron indices come from a small pool so that the same
    // neuron is stepped repeatedly and builds up to firing. Time walks
    // forward mostly, with occasional wild values.
    int sim_now = 0;
    function automatic t_cmd rand_cmd(input int pool);
        t_cmd c;
        c.neuron = 10'($urandom_range(pool - 1, 0));
        if ($urandom_range(9, 0) == 0) c.neuron = 10'($urandom);
        sim_now += $urandom_range(20000, 0);
        c.now = sim_now;
        if ($urandom_range(19, 0) == 0) c.now = $urandom;
        case ($urandom_range(3, 0))
            0: c.bias = $urandom;
            1: c.bias = 32'($signed($urandom_range(200, 0)) - 100) <<< 16;
            default: c.bias = $urandom_range(400, 0) << 16;
        endcase
        c.drive = ($urandom_range(4, 0) == 0) ? $urandom : $urandom_range(600, 0) << 16;
        c.active = ($urandom_range(4, 0) == 0) ? 16'($urandom) : 16'($urandom_range(20, 0));
        c.fan = ($urandom_range(5, 0) == 0) ? 16'd0
              : ($urandom_range(4, 0) == 0) ? 16'($urandom) : 16'($urandom_range(30, 1));
        c.gap = ($urandom_range(3, 0) == 0) ? $urandom_range(13, 0) : 0;
        return c;
    endfunction

    initial begin
        t_cmd c;
        for (int k = 0; k < NEURONS_DEF; k++) begin
            pot_mem[k] = MEM_V_RST;
            rel_mem[k] = MEM_REL_RST;
        end
        gain_q = GAIN_RST;
        step_q = STEP_RST;
        peak_q = PEAK_RST;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: field extremes, zero fan-in, the highest index, repeated steps on
        // one neuron, then a step on it far ahead in time.
        c = '{neuron: 0, now: 32'h8000_0000, bias: 0, active: 0, fan: 0, drive: 0, gap: 0};
        queue_cmd(c); // time equal to the reset release time: refractory
        c = '{neuron: 1, now: 32'h7FFF_FFFF, bias: 32'h7FFF_FFFF, active: 16'hFFFF,
              fan: 16'hFFFF, drive: 32'h7FFF_FFFF, gap: 3};
        queue_cmd(c);
        c = '{neuron: 2, now: 0, bias: 32'h8000_0000, active: 16'hFFFF,
              fan: 0, drive: 32'h8000_0000, gap: 0};
        queue_cmd(c);
        c = '{neuron: 10'h3FF, now: 32'h1234, bias: 32'h7FFF_FFFF, active: 1,
              fan: 1, drive: 0, gap: 0};
        queue_cmd(c);
        c = '{neuron: 3, now: 100, bias: 32'h0100_0000, active: 16'hFFFF,
              fan: 1, drive: 32'h0100_0000, gap: 0};
        queue_cmd(c);
        c.now = 200;
        queue_cmd(c);
        c.now = 300;
        queue_cmd(c);
        c = '{neuron: 3, now: 32'h7FFF_0000, bias: 0, active: 0, fan: 0, drive: 0, gap: 1};
        queue_cmd(c);
        wait_idle();

        // Large step and small peak force firing; then a step size of zero.
        write_reg(REG_STEP, 32'd16777216);
        write_reg(REG_PEAK, 32'd65536);
        write_reg(REG_GAIN, 32'h7FFF_FFFF);
        for (int k = 0; k < 12; k++) begin
            c = '{neuron: 10'(k % 4), now: 32'(k * 1000), bias: 32'(k) << 16,
                  active: 16'(k), fan: 16'(k % 3), drive: 0, gap: 0};
            queue_cmd(c);
        end
        wait_idle();
        write_reg(REG_STEP, 32'd0);
        write_reg(REG_PEAK, 32'd0);
        write_reg(REG_GAIN, 32'd0);
        c = '{neuron: 20, now: 32'h4000_0000, bias: 32'h7FFF_FFFF, active: 5, fan: 2,
              drive: 32'h7FFF_FFFF, gap: 0};
        queue_cmd(c);
        c = '{neuron: 21, now: 32'h4000_0000, bias: 0, active: 0, fan: 0,
              drive: 0, gap: 0};
        queue_cmd(c);
        wait_idle();

        // Random phases over several register settings.
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    write_reg(REG_GAIN, 32'(GAIN_RST));
                    write_reg(REG_STEP, 32'd200000);
                    write_reg(REG_PEAK, 32'(PEAK_RST));
                end
                1: begin
                    write_reg(REG_GAIN, $urandom);
                    write_reg(REG_STEP, $urandom_range(16777216, 1));
                    write_reg(REG_PEAK, $urandom_range(32'h7FFF_FFFF, 65536));
                end
                2: begin
                    write_reg(REG_GAIN, 32'h7FFF_FFFF);
                    write_reg(REG_STEP, 32'd16777216);
                    write_reg(REG_PEAK, 32'h7FFF_FFFF);
                end
                default: begin
                    write_reg(REG_GAIN, 32'd1000 << 16);
                    write_reg(REG_STEP, 32'd50000);
                    write_reg(REG_PEAK, 32'd65536 * 20);
                end
            endcase
            for (int k = 0; k < 80; k++) begin
                // Mid-phase, hold off until everything in flight has returned.
                if (k == 50) begin
                    while (pending_cmds.size() > 0 || have_cmd
                           || expected_upds.size() > 0)
                        @(posedge i_clk);
                end
                queue_cmd(rand_cmd(ph == 2 ? 64 : 8));
                // A burst without gaps now and then.
                if (k % 30 == 0) begin
                    for (int b = 0; b < 5; b++) begin
                        c = rand_cmd(1024);
                        c.gap = 0;
                        queue_cmd(c);
                    end
                end
            end
            wait_idle();
        end
        stim_done = 1'b1;

        $display("Ran %0d results: %0d spikes, %0d refractory or out-of-range.",
                 results_seen, spikes_seen, refractory_seen);
        if (mismatches == 0 && expected_upds.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // Watchdog: clear pass, about four hundred items with gaps and stalls,
    // and the drains.
    initial begin
        #5ms;
        $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire
